### design/mees_pkg.sv
// ----------------------------------------------------------------------------
// mees_pkg
// Shared types and constants of the MIDI echo event scheduler.
// ----------------------------------------------------------------------------
package mees_pkg;

  localparam int SLOTS_DEF   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int KW          = $clog2(MAX_RESULTS + 1);
  localparam int QDEPTH      = 4;
  localparam int DIV_NW      = 32;
  localparam int DIV_DW      = 16;

  localparam logic [1:0] KIND_NOTE    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_SILENCE = 2'd2;

  localparam logic [1:0] OP_ENTRY   = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_SILENCE = 2'd2;

  localparam logic [2:0] CFG_ECHO_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_TOUCH_LOW    = 3'd1;
  localparam logic [2:0] CFG_TOUCH_HIGH   = 3'd2;
  localparam logic [2:0] CFG_REPEATS_MIN  = 3'd3;
  localparam logic [2:0] CFG_REPEATS_MAX  = 3'd4;
  localparam logic [2:0] CFG_DELAY_MIN_MS = 3'd5;
  localparam logic [2:0] CFG_DELAY_MAX_MS = 3'd6;

  typedef struct packed {
    logic        echo_enable;
    logic [15:0] touch_low;
    logic [15:0] touch_high;
    logic [4:0]  repeats_min;
    logic [4:0]  repeats_max;
    logic [15:0] delay_min_ms;
    logic [15:0] delay_max_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] delay;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [4:0]  ch;
    logic [3:0]  port;
    logic        rel;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } q_rd_t;

  typedef struct packed {
    logic [6:0] note;
    logic [6:0] vel;
    logic [4:0] ch;
    logic [3:0] port;
    logic       rel;
  } out_t;

endpackage

### design/midi_echo_event_scheduler.sv
// A tick or silence request, once it leaves the queue, reads and evaluates each slot in turn
// and ends in a flush state; results stream during the scan, the flush releasing the last one.
// Busy is high through the push of a tick or silence and through a note-on's planning (repeat
// and interval divisions, skipped on a flat range, then one velocity division per repeat), and
// longer while the queue is full, as each queued entry waits on the back end's free-slot search.
// Reset (synchronous, rst_n low): counter zero, all slots free, registers at defaults.
// ----------------------------------------------------------------------------
// midi_echo_event_scheduler
// Timed note-echo engine: note-ons schedule repeats, ticks release due entries, silence releases held notes.
// ----------------------------------------------------------------------------
module midi_echo_event_scheduler import mees_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_channel,
  input  logic [6:0]  in_note_number,
  input  logic [6:0]  in_velocity,
  input  logic [3:0]  in_port,
  input  logic [15:0] in_touch_level,
  output logic        out_valid,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic [4:0]  out_channel,
  output logic [3:0]  out_port,
  output logic        out_is_release,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg_r;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.echo_enable  <= 1'b0;
      cfg_r.touch_low    <= 16'd1000;
      cfg_r.touch_high   <= 16'd4000;
      cfg_r.repeats_min  <= 5'd1;
      cfg_r.repeats_max  <= 5'd8;
      cfg_r.delay_min_ms <= 16'd100;
      cfg_r.delay_max_ms <= 16'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ECHO_ENABLE:  cfg_r.echo_enable  <= cfg_data[0];
        CFG_TOUCH_LOW:    cfg_r.touch_low    <= cfg_data;
        CFG_TOUCH_HIGH:   cfg_r.touch_high   <= cfg_data;
        CFG_REPEATS_MIN:  cfg_r.repeats_min  <= cfg_data[4:0];
        CFG_REPEATS_MAX:  cfg_r.repeats_max  <= cfg_data[4:0];
        CFG_DELAY_MIN_MS: cfg_r.delay_min_ms <= cfg_data;
        CFG_DELAY_MAX_MS: cfg_r.delay_max_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  mees_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_channel     (in_channel),
    .in_note_number (in_note_number),
    .in_velocity    (in_velocity),
    .in_port        (in_port),
    .in_touch_level (in_touch_level),
    .q_wr           (q_wr),
    .q_full         (q_full)
  );

  mees_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rd    (q_rd)
  );

  mees_back #(.SLOTS(SLOTS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_note        (out_note),
    .out_velocity    (out_velocity),
    .out_channel     (out_channel),
    .out_port        (out_port),
    .out_is_release  (out_is_release),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### design/mees_div.sv
// ----------------------------------------------------------------------------
// mees_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mees_div import mees_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  localparam int CW = $clog2(DIV_NW);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

### design/mees_fifo.sv
// ----------------------------------------------------------------------------
// mees_fifo
// Short command queue between the planning front and the slot back end.
// ----------------------------------------------------------------------------
module mees_fifo import mees_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t wr,
  output logic  full,
  input  logic  pop,
  output q_rd_t rd
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t          mem [QDEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = cnt_r == (PW+1)'(QDEPTH);
  assign rd.empty = cnt_r == '0;
  assign rd.cmd  = mem[rp_r];
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !rd.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wr.cmd;
  end

endmodule

### design/mees_front.sv
// ----------------------------------------------------------------------------
// mees_front
// Accepts items, maps touch to repeat count and interval, and queues slot
// entries, ticks and silence requests in order.
// ----------------------------------------------------------------------------
module mees_front import mees_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_channel,
  input  logic [6:0]  in_note_number,
  input  logic [6:0]  in_velocity,
  input  logic [3:0]  in_port,
  input  logic [15:0] in_touch_level,
  output q_wr_t       q_wr,
  input  logic        q_full
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PUSH     = 4'd1;
  localparam logic [3:0] S_MUL_N    = 4'd2;
  localparam logic [3:0] S_DIV_N    = 4'd3;
  localparam logic [3:0] S_MUL_D    = 4'd4;
  localparam logic [3:0] S_DIV_D    = 4'd5;
  localparam logic [3:0] S_DIV_OFF  = 4'd6;
  localparam logic [3:0] S_DIV_V    = 4'd7;
  localparam logic [3:0] S_PUSH_ON  = 4'd8;
  localparam logic [3:0] S_PUSH_OFF = 4'd9;

  logic [3:0]  state_r;
  logic        div_go_r;
  logic [1:0]  op_r;
  logic [4:0]  ch_r;
  logic [6:0]  note_r;
  logic [6:0]  vel_r;
  logic [3:0]  port_r;
  logic [15:0] touch_r;
  logic [31:0] prod_r;
  logic        neg_r;
  logic [4:0]  n_r;
  logic [15:0] d_r;
  logic [4:0]  r_r;
  logic [31:0] on_r;
  logic [15:0] offadd_r;
  logic [6:0]  v_r;

  logic              div_done;
  logic [DIV_NW-1:0] div_quot;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [15:0]       span;
  logic [15:0]       xoff;
  logic [5:0]        vmul;
  logic signed [33:0] q_s;
  logic signed [33:0] q_signed;
  logic [15:0]       n_fix;
  logic [15:0]       d_fix;
  logic [15:0]       n_flat;
  logic [15:0]       d_flat;
  logic              flat;
  logic [32:0]       off_prod;

  function automatic logic [15:0] clamp16(input logic signed [33:0] m,
                                          input logic [15:0] lo,
                                          input logic [15:0] hi);
    logic signed [33:0] slo;
    logic signed [33:0] shi;
    slo = $signed({18'b0, lo});
    shi = $signed({18'b0, hi});
    if (m < slo) return lo;
    else if (m > shi) return hi;
    else return m[15:0];
  endfunction

  assign busy = state_r != S_IDLE;
  assign span = cfg.touch_high - cfg.touch_low;
  assign xoff = touch_r - cfg.touch_low;
  assign flat = cfg.touch_high <= cfg.touch_low;
  assign vmul = 6'(n_r) - 6'(r_r) + 6'd1;

  // two thirds of the interval: 2*d times ceil(2^17/3), exact for 2*d below 2^17
  assign off_prod = 33'({d_r, 1'b0}) * 33'd43691;

  assign q_s      = $signed({2'b00, div_quot});
  assign q_signed = neg_r ? -q_s : q_s;
  assign n_fix    = clamp16(q_signed + $signed({29'b0, cfg.repeats_min}),
                            {11'b0, cfg.repeats_min}, {11'b0, cfg.repeats_max});
  assign d_fix    = clamp16(q_signed + $signed({18'b0, cfg.delay_min_ms}),
                            cfg.delay_min_ms, cfg.delay_max_ms);
  assign n_flat   = clamp16($signed({29'b0, cfg.repeats_max}),
                            {11'b0, cfg.repeats_min}, {11'b0, cfg.repeats_max});
  assign d_flat   = clamp16($signed({18'b0, cfg.delay_max_ms}),
                            cfg.delay_min_ms, cfg.delay_max_ms);

  always_comb begin
    div_num = prod_r;
    div_den = span;
    unique case (state_r)
      S_DIV_V: begin
        div_num = 32'(vel_r * vmul);
        div_den = 16'(n_r) + 16'd1;
      end
      default: begin
        div_num = prod_r;
        div_den = span;
      end
    endcase
  end

  mees_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    q_wr.push      = 1'b0;
    q_wr.cmd.op    = OP_ENTRY;
    q_wr.cmd.delay = on_r;
    q_wr.cmd.note  = note_r;
    q_wr.cmd.vel   = v_r;
    q_wr.cmd.ch    = ch_r;
    q_wr.cmd.port  = port_r;
    q_wr.cmd.rel   = 1'b0;
    unique case (state_r)
      S_PUSH: begin
        q_wr.push   = 1'b1;
        q_wr.cmd.op = op_r;
      end
      S_PUSH_ON: q_wr.push = 1'b1;
      S_PUSH_OFF: begin
        q_wr.push      = 1'b1;
        q_wr.cmd.delay = on_r + 32'(offadd_r);
        q_wr.cmd.vel   = '0;
        q_wr.cmd.rel   = 1'b1;
      end
      default: q_wr.push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_kind == KIND_NOTE) begin
              if (cfg.echo_enable && in_touch_level >= cfg.touch_low) state_r <= S_MUL_N;
            end else if (in_kind == KIND_TICK || in_kind == KIND_SILENCE) begin
              state_r <= S_PUSH;
            end
          end
        end
        S_PUSH: if (!q_full) state_r <= S_IDLE;
        S_MUL_N: begin
          if (flat) begin
            state_r <= S_MUL_D;
          end else begin
            state_r  <= S_DIV_N;
            div_go_r <= 1'b1;
          end
        end
        S_DIV_N: if (div_done) state_r <= S_MUL_D;
        S_MUL_D: begin
          if (flat) begin
            state_r <= (n_r == '0) ? S_IDLE : S_DIV_OFF;
          end else begin
            state_r  <= S_DIV_D;
            div_go_r <= 1'b1;
          end
        end
        S_DIV_D: begin
          if (div_done) state_r <= (n_r == '0) ? S_IDLE : S_DIV_OFF;
        end
        S_DIV_OFF: begin
          state_r  <= S_DIV_V;
          div_go_r <= 1'b1;
        end
        S_DIV_V:   if (div_done) state_r <= S_PUSH_ON;
        S_PUSH_ON: if (!q_full) state_r <= S_PUSH_OFF;
        S_PUSH_OFF: begin
          if (!q_full) begin
            if (r_r == n_r) begin
              state_r <= S_IDLE;
            end else begin
              state_r  <= S_DIV_V;
              div_go_r <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        op_r    <= (in_kind == KIND_TICK) ? OP_TICK : OP_SILENCE;
        ch_r    <= in_channel;
        note_r  <= in_note_number;
        vel_r   <= in_velocity;
        port_r  <= in_port;
        touch_r <= in_touch_level;
      end
      S_MUL_N: begin
        if (flat) n_r <= n_flat[4:0];
        prod_r <= 32'(xoff * ((cfg.repeats_max >= cfg.repeats_min) ?
                  (cfg.repeats_max - cfg.repeats_min) : (cfg.repeats_min - cfg.repeats_max)));
        neg_r  <= cfg.repeats_max < cfg.repeats_min;
      end
      S_DIV_N: if (div_done) n_r <= n_fix[4:0];
      S_MUL_D: begin
        if (flat) begin
          d_r  <= d_flat;
          on_r <= 32'(d_flat);
        end
        prod_r <= 32'(xoff * ((cfg.delay_max_ms >= cfg.delay_min_ms) ?
                  (cfg.delay_max_ms - cfg.delay_min_ms) : (cfg.delay_min_ms - cfg.delay_max_ms)));
        neg_r  <= cfg.delay_max_ms < cfg.delay_min_ms;
        r_r    <= 5'd1;
      end
      S_DIV_D: begin
        if (div_done) begin
          d_r  <= d_fix;
          on_r <= 32'(d_fix);
        end
      end
      S_DIV_OFF: offadd_r <= off_prod[32:17];
      S_DIV_V: if (div_done) v_r <= (div_quot == '0) ? 7'd1 : div_quot[6:0];
      S_PUSH_OFF: begin
        if (!q_full) begin
          r_r  <= r_r + 1'b1;
          on_r <= on_r + 32'(d_r);
        end
      end
      default: ;
    endcase
  end

endmodule

### design/mees_back.sv
// ----------------------------------------------------------------------------
// mees_back
// Slot table: places entries in the lowest free slot, scans on tick and
// silence, and drives the result strobe.
// ----------------------------------------------------------------------------
module mees_back import mees_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  q_rd_t      q_rd,
  output logic       q_pop,
  output logic       out_valid,
  output logic [6:0] out_note,
  output logic [6:0] out_velocity,
  output logic [4:0] out_channel,
  output logic [3:0] out_port,
  output logic       out_is_release,
  output logic       out_last_of_run
);

  localparam int IW = $clog2(SLOTS);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_INS   = 3'd1;
  localparam logic [2:0] B_RD    = 3'd2;
  localparam logic [2:0] B_EV    = 3'd3;
  localparam logic [2:0] B_FLUSH = 3'd4;

  typedef struct packed {
    logic [31:0] due;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [4:0]  ch;
    logic [3:0]  port;
    logic        rel;
  } slot_t;

  slot_t          mem [SLOTS];
  slot_t          rd_q;
  logic [2:0]     state_r;
  cmd_t           cmd_r;
  logic [31:0]    now_r;
  logic [SLOTS-1:0] active_r;
  logic [IW-1:0]  idx_r;
  logic [KW-1:0]  k_r;
  logic           pend_v_r;
  out_t           pend_r;
  logic           out_valid_r;
  out_t           out_r;
  logic           out_last_r;

  logic           last_slot;
  logic           hit;
  logic           room;
  out_t           item;

  assign q_pop     = state_r == B_IDLE && !q_rd.empty;
  assign last_slot = idx_r == IW'(SLOTS - 1);
  assign room      = k_r < KW'(MAX_RESULTS);

  always_comb begin
    item.note = rd_q.note;
    item.ch   = rd_q.ch;
    item.port = rd_q.port;
    if (cmd_r.op == OP_TICK) begin
      hit      = active_r[idx_r] && now_r >= rd_q.due && room;
      item.rel = rd_q.rel;
      item.vel = rd_q.rel ? 7'd0 : rd_q.vel;
    end else begin
      hit      = active_r[idx_r] && !rd_q.rel && room;
      item.rel = 1'b1;
      item.vel = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_INS && !active_r[idx_r]) begin
      mem[idx_r] <= '{due: now_r + cmd_r.delay, note: cmd_r.note, vel: cmd_r.vel,
                      ch: cmd_r.ch, port: cmd_r.port, rel: cmd_r.rel};
    end
    rd_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      now_r       <= '0;
      active_r    <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_rd.empty) begin
            idx_r <= '0;
            k_r   <= '0;
            if (q_rd.cmd.op == OP_TICK) begin
              now_r   <= now_r + 32'd1;
              state_r <= B_RD;
            end else if (q_rd.cmd.op == OP_SILENCE) begin
              state_r <= B_RD;
            end else begin
              state_r <= B_INS;
            end
          end
        end
        B_INS: begin
          // take the first free slot, drop the entry when none is left
          if (!active_r[idx_r]) begin
            active_r[idx_r] <= 1'b1;
            state_r         <= B_IDLE;
          end else if (last_slot) begin
            state_r <= B_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        B_RD: state_r <= B_EV;
        B_EV: begin
          if (hit) begin
            k_r      <= k_r + 1'b1;
            pend_v_r <= 1'b1;
            if (pend_v_r) begin
              out_valid_r <= 1'b1;
              out_last_r  <= 1'b0;
              out_r       <= pend_r;
            end
          end
          if (hit || cmd_r.op == OP_SILENCE) active_r[idx_r] <= 1'b0;
          if (last_slot) begin
            state_r <= B_FLUSH;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= B_RD;
          end
        end
        B_FLUSH: begin
          if (pend_v_r) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_r       <= pend_r;
            pend_v_r    <= 1'b0;
          end
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // hold one emission back so the last of a run can be marked
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && !q_rd.empty) cmd_r <= q_rd.cmd;
    if (state_r == B_EV && hit) pend_r <= item;
  end

  assign out_valid       = out_valid_r;
  assign out_note        = out_r.note;
  assign out_velocity    = out_r.vel;
  assign out_channel     = out_r.ch;
  assign out_port        = out_r.port;
  assign out_is_release  = out_r.rel;
  assign out_last_of_run = out_last_r;

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= KW'(MAX_RESULTS))
    else $error("result count exceeded limit");

  a_silence_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FLUSH && cmd_r.op == OP_SILENCE) |-> active_r == '0)
    else $error("slots still active after silence");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !pend_v_r)
    else $error("held result left after last of run");

  a_ins_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_INS && !active_r[idx_r]) |=> state_r == B_IDLE)
    else $error("insert did not finish after finding a free slot");

endmodule

### tb/sv/tb_midi_echo_event_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_echo_event_scheduler
// Self-checking bench for the note-echo scheduler. A scoreboard predicts the
// slot table, the millisecond counter and every emitted message for each
// accepted request and checks the result stream in order. Directed cases
// cover the full table, a 32-message tick, silence, bad and swapped ranges
// and the register extremes; random phases run under several idle rates.
// ----------------------------------------------------------------------------
module tb_midi_echo_event_scheduler import mees_pkg::*; ();

  localparam int NSLOT  = 32;
  localparam int SETTLE = 4000;      // note-on work left after the last result
  localparam int LIMIT  = 1500000;

  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [6:0] note;
    logic [6:0] vel;
    logic [4:0] ch;
    logic [3:0] port;
    logic       rel;
    logic       last;
  } echo_msg_t;

  class echo_scoreboard;
    bit        en;
    bit [15:0] tlo, thi, dmin, dmax;
    bit [4:0]  rmin, rmax;
    bit [31:0] now_ms;
    bit        act[NSLOT];
    bit [31:0] due[NSLOT];
    bit [6:0]  s_note[NSLOT];
    bit [6:0]  s_vel[NSLOT];
    bit [4:0]  s_ch[NSLOT];
    bit [3:0]  s_port[NSLOT];
    bit        s_rel[NSLOT];
    echo_msg_t pending_q[$];
    int        errors;

    function new();
      en = 0; tlo = 1000; thi = 4000; rmin = 1; rmax = 8; dmin = 100; dmax = 500;
      now_ms = 0;
      errors = 0;
      foreach (act[i]) act[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_ECHO_ENABLE:  en   = data[0];
        CFG_TOUCH_LOW:    tlo  = data;
        CFG_TOUCH_HIGH:   thi  = data;
        CFG_REPEATS_MIN:  rmin = data[4:0];
        CFG_REPEATS_MAX:  rmax = data[4:0];
        CFG_DELAY_MIN_MS: dmin = data;
        CFG_DELAY_MAX_MS: dmax = data;
        default: ;
      endcase
    endfunction

    function longint map_touch(longint x, longint lo, longint hi, longint omin,
                               longint omax);
      if (hi <= lo) return omax;
      return (x - lo) * (omax - omin) / (hi - lo) + omin;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function void take_slot(bit [31:0] when, bit [4:0] ch, bit [6:0] nt, bit [6:0] v,
                            bit [3:0] pt, bit rel);
      for (int i = 0; i < NSLOT; i++) begin
        if (!act[i]) begin
          act[i] = 1; due[i] = when; s_note[i] = nt; s_vel[i] = v;
          s_ch[i] = ch; s_port[i] = pt; s_rel[i] = rel;
          return;
        end
      end
    endfunction

    function void push_msg(int i, bit rel);
      echo_msg_t m;
      m.note = s_note[i]; m.vel = rel ? 7'd0 : s_vel[i]; m.ch = s_ch[i];
      m.port = s_port[i]; m.rel = rel; m.last = 0;
      pending_q.push_back(m);
    endfunction

    function void note_request(logic [1:0] kind, logic [4:0] ch, logic [6:0] nt,
                               logic [6:0] vel, logic [3:0] pt, logic [15:0] touch);
      longint n, d, v;
      bit [31:0] on_d, off_d;
      int k;
      k = 0;
      case (kind)
        KIND_NOTE: begin
          if (en && touch >= tlo) begin
            n = clamp(map_touch(touch, tlo, thi, rmin, rmax), rmin, rmax);
            d = clamp(map_touch(touch, tlo, thi, dmin, dmax), dmin, dmax);
            for (longint r = 1; r <= n; r++) begin
              on_d  = 32'(r * d);
              off_d = on_d + 32'(d * 2 / 3);
              v = clamp((longint'(vel) * (n - r + 1)) / (n + 1), 1, 127);
              take_slot(now_ms + on_d, ch, nt, 7'(v), pt, 0);
              take_slot(now_ms + off_d, ch, nt, 7'd0, pt, 1);
            end
          end
        end
        KIND_TICK: begin
          now_ms = now_ms + 1;
          for (int i = 0; i < NSLOT && k < MAX_RESULTS; i++) begin
            if (act[i] && now_ms >= due[i]) begin
              act[i] = 0;
              push_msg(i, s_rel[i]);
              k++;
            end
          end
        end
        KIND_SILENCE: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (act[i] && !s_rel[i] && k < MAX_RESULTS) begin
              push_msg(i, 1);
              k++;
            end
            act[i] = 0;
          end
        end
        default: ;
      endcase
      if (k > 0) pending_q[pending_q.size() - 1].last = 1;
    endfunction

    function void check_result(echo_msg_t got);
      echo_msg_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected message note=%0d vel=%0d ch=%0d port=%0d rel=%0d",
                 $time, got.note, got.vel, got.ch, got.port, got.rel);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.note !== want.note) begin
        $display("%0t: note exp %0d got %0d", $time, want.note, got.note); errors++;
      end
      if (got.vel !== want.vel) begin
        $display("%0t: velocity exp %0d got %0d", $time, want.vel, got.vel); errors++;
      end
      if (got.ch !== want.ch) begin
        $display("%0t: channel exp %0d got %0d", $time, want.ch, got.ch); errors++;
      end
      if (got.port !== want.port) begin
        $display("%0t: port exp %0d got %0d", $time, want.port, got.port); errors++;
      end
      if (got.rel !== want.rel) begin
        $display("%0t: is_release exp %0d got %0d", $time, want.rel, got.rel); errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_of_run exp %0d got %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_kind = 0;
  logic [4:0]  in_channel = 1;
  logic [6:0]  in_note_number = 0;
  logic [6:0]  in_velocity = 0;
  logic [3:0]  in_port = 0;
  logic [15:0] in_touch_level = 0;
  logic        out_valid;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic [4:0]  out_channel;
  logic [3:0]  out_port;
  logic        out_is_release;
  logic        out_last_of_run;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;

  echo_scoreboard sb = new();
  int gap_pct = 0;
  int cycles = 0;

  midi_echo_event_scheduler u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_midi_echo_event_scheduler: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    echo_msg_t m;
    if (rst_n && out_valid) begin
      m.note = out_note; m.vel = out_velocity; m.ch = out_channel;
      m.port = out_port; m.rel = out_is_release; m.last = out_last_of_run;
      sb.check_result(m);
    end
  end

  task automatic send(logic [1:0] kind, logic [4:0] ch, logic [6:0] nt, logic [6:0] vel,
                      logic [3:0] pt, logic [15:0] touch);
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    start = 1; in_kind = kind; in_channel = ch; in_note_number = nt;
    in_velocity = vel; in_port = pt; in_touch_level = touch;
    do @(posedge clk); while (busy);
    sb.note_request(kind, ch, nt, vel, pt, touch);
  endtask

  task automatic tick();
    send(KIND_TICK, 1, 0, 0, 0, 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    start = 0; cfg_valid = 1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic load_regs(bit en, int lo, int hi, int rmn, int rmx, int dmn, int dmx);
    write_reg(CFG_ECHO_ENABLE, 16'(en));
    write_reg(CFG_TOUCH_LOW, 16'(lo));
    write_reg(CFG_TOUCH_HIGH, 16'(hi));
    write_reg(CFG_REPEATS_MIN, 16'(rmn));
    write_reg(CFG_REPEATS_MAX, 16'(rmx));
    write_reg(CFG_DELAY_MIN_MS, 16'(dmn));
    write_reg(CFG_DELAY_MAX_MS, 16'(dmx));
  endtask

  // hold off until the result stream drains, then let note-on work finish
  task automatic drain(int extra);
    @(negedge clk);
    start = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic random_run(int count);
    int r;
    logic [15:0] touch;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      touch = $urandom_range(0, 1) ? 16'($urandom) : 16'(sb.tlo + $urandom_range(0, 3000));
      if (r < 25)
        send(KIND_NOTE, 5'($urandom_range(1, 16)), 7'($urandom), 7'($urandom),
             4'($urandom), touch);
      else if (r < 88)
        send(KIND_TICK, 5'($urandom), 7'($urandom), 7'($urandom), 4'($urandom), touch);
      else if (r < 97)
        send(KIND_SILENCE, 5'($urandom), 7'($urandom), 7'($urandom), 4'($urandom), touch);
      else
        send(KIND_NONE, 5'($urandom), 7'($urandom), 7'($urandom), 4'($urandom), touch);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1;

    // zero interval fills the whole table at once: one tick emits 32 messages
    load_regs(1, 100, 1000, 16, 16, 0, 0);
    send(KIND_NONE, 16, 127, 127, 15, 16'hFFFF);
    send(KIND_NOTE, 16, 127, 127, 15, 99);
    send(KIND_NOTE, 16, 127, 127, 15, 100);
    send(KIND_NOTE, 1, 0, 0, 0, 16'hFFFF);          // table full: dropped
    tick();
    tick();
    send(KIND_NOTE, 3, 60, 1, 9, 500);
    send(KIND_SILENCE, 0, 0, 0, 0, 0);
    tick();
    drain(SETTLE);

    load_regs(1, 100, 1000, 1, 8, 2, 9);
    send(KIND_NOTE, 10, 64, 127, 5, 1000);
    send(KIND_NOTE, 11, 65, 64, 6, 100);
    send(KIND_NOTE, 12, 66, 0, 7, 550);
    repeat (12) tick();
    send(KIND_SILENCE, 0, 0, 0, 0, 0);
    repeat (3) tick();
    drain(SETTLE);

    gap_pct = 0;
    load_regs(1, 200, 3000, 1, 6, 1, 12);
    random_run(80);
    drain(SETTLE);

    // bad mapping range and swapped clamp bounds
    gap_pct = 74;
    load_regs(1, 5000, 5000, 20, 3, 3, 0);
    random_run(70);
    drain(SETTLE);

    gap_pct = 9;
    load_regs(1, 0, 65535, 0, 31, 0, 40);
    random_run(70);
    drain(SETTLE);

    gap_pct = 0;
    load_regs(1, 65535, 0, 31, 0, 65535, 65535);
    send(KIND_NOTE, 7, 100, 90, 2, 16'hFFFF);
    repeat (3) tick();
    send(KIND_SILENCE, 0, 0, 0, 0, 0);
    drain(SETTLE);
    write_reg(CFG_ECHO_ENABLE, 0);
    send(KIND_NOTE, 7, 100, 90, 2, 16'hFFFF);
    repeat (5) tick();
    send(KIND_SILENCE, 0, 0, 0, 0, 0);

    drain(SETTLE);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb_midi_echo_event_scheduler: done, clean");
    else
      $display("tb_midi_echo_event_scheduler: done, errors");
    $finish;
  end

endmodule
